// ----- rtl/core/tlbpt_pkg.sv -----
// Shared widths and interface structs for the TLB page translator.
package tlbpt_pkg;

    localparam int ADDR_W   = 16;
    localparam int PAGE_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int FRAME_W  = 8;
    localparam int COUNT_W  = 16;
    // One bit more than a page number so that the frame allocator can reach PAGE_COUNT.
    localparam int FREE_W   = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlbpt_lookup_t;

    typedef struct packed {
        logic               touch;
        logic               install;
        logic [FRAME_W-1:0] frame;
    } tlbpt_update_t;

endpackage

// ----- rtl/core/tlbpt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tlbpt_tlb.sv -----
// Fully associative TLB with least-recently-used ranking held per entry.
module tlbpt_tlb #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tlbpt_pkg::PAGE_W-1:0]     page,
    input  tlbpt_pkg::tlbpt_update_t         upd,
    output tlbpt_pkg::tlbpt_lookup_t         lookup
);

    localparam int SLOT_W = $clog2(TLB_ENTRIES);
    localparam int AGE_W  = $clog2(TLB_ENTRIES);
    localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(TLB_ENTRIES - 1);

    logic [tlbpt_pkg::PAGE_W-1:0]  page_reg  [TLB_ENTRIES];
    logic [tlbpt_pkg::PAGE_W-1:0]  page_next [TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0] frame_reg  [TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0] frame_next [TLB_ENTRIES];
    logic [AGE_W-1:0]              age_reg  [TLB_ENTRIES];
    logic [AGE_W-1:0]              age_next [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]        valid_reg;
    logic [TLB_ENTRIES-1:0]        valid_next;

    logic [TLB_ENTRIES-1:0] match_vec;
    logic [TLB_ENTRIES-1:0] last_vec;
    logic [SLOT_W-1:0]      hit_slot;
    logic [SLOT_W-1:0]      free_slot;
    logic [SLOT_W-1:0]      oldest_slot;
    logic [SLOT_W-1:0]      inst_slot;
    logic                   any_free;
    logic [AGE_W-1:0]       hit_age;

    // Priority searches: scanning downward leaves the lowest index selected.
    always_comb
    begin
        hit_slot    = '0;
        free_slot   = '0;
        oldest_slot = '0;
        any_free    = 1'b0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = valid_reg[i] && (page_reg[i] == page);
            last_vec[i]  = valid_reg[i] && (age_reg[i] == AGE_LAST);
            if (match_vec[i])
            begin
                hit_slot = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
                any_free  = 1'b1;
            end
            if (last_vec[i])
            begin
                oldest_slot = SLOT_W'(i);
            end
        end
    end

    // Ages of valid entries always form a permutation, so when the TLB is full the
    // least recently used entry is the one whose age is the last rank.
    assign inst_slot    = any_free ? free_slot : oldest_slot;
    assign hit_age      = age_reg[hit_slot];
    assign lookup.hit   = |match_vec;
    assign lookup.frame = frame_reg[hit_slot];

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            page_next[i]  = page_reg[i];
            frame_next[i] = frame_reg[i];
            age_next[i]   = age_reg[i];
            valid_next[i] = valid_reg[i];
            if (upd.touch)
            begin
                if (SLOT_W'(i) == hit_slot)
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && (age_reg[i] < hit_age))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            else if (upd.install)
            begin
                if (SLOT_W'(i) == inst_slot)
                begin
                    page_next[i]  = page;
                    frame_next[i] = upd.frame;
                    age_next[i]   = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i] && (age_reg[i] < AGE_LAST))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            page_reg[i]  <= page_next[i];
            frame_reg[i] <= frame_next[i];
        end
    end

    // A page is held by at most one valid entry.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match_vec))
        else $error("tlb: page matches more than one entry");

    // A full TLB has exactly one entry in the last recency rank.
    assert property (@(posedge clk) disable iff (!rst_n) (&valid_reg) |-> $onehot(last_vec))
        else $error("tlb: recency ranks are not a permutation");

endmodule

// ----- rtl/core/tlb_lru_page_translator.sv -----
// Top level: address translation through an LRU TLB backed by a page table.
//
// Usage: drive logical_address and raise start for one cycle per transaction.
// busy is always low, so a transaction is taken on every edge where start is high.
// Each transaction produces one result transaction: done is high for exactly one
// cycle and physical_address, tlb_hit, page_fault, frames_exhausted, hit_total and
// fault_total are valid in that cycle only.
// Throughput is one transaction per cycle. The accepting edge registers the address
// and reads the page-table RAM (registered read); after that the design searches the
// TLB, resolves hit, table hit or fault and updates the TLB, valid bits and counters.
// Reset clears the TLB, all page-table valid bits, the frame allocator and both
// totals at once; no clearing pass is needed and start may be raised right away.
// The receiver cannot stall: a result is gone after its done cycle.
module tlb_lru_page_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tlbpt_pkg::ADDR_W-1:0]      logical_address,
    output logic                              done,
    output logic [tlbpt_pkg::ADDR_W-1:0]      physical_address,
    output logic                              tlb_hit,
    output logic                              page_fault,
    output logic                              frames_exhausted,
    output logic [tlbpt_pkg::COUNT_W-1:0]     hit_total,
    output logic [tlbpt_pkg::COUNT_W-1:0]     fault_total
);

    localparam int IDX_W = $clog2(PAGE_COUNT);
    localparam logic [tlbpt_pkg::FREE_W-1:0] PAGE_LIMIT = PAGE_COUNT[tlbpt_pkg::FREE_W-1:0];

    logic                                accept;
    logic                                valid_s1_reg;
    logic [tlbpt_pkg::PAGE_W-1:0]        page_s1_reg;
    logic [tlbpt_pkg::OFFSET_W-1:0]      offset_s1_reg;
    logic [IDX_W-1:0]                    page_idx;
    logic [IDX_W-1:0]                    rd_idx;
    logic [tlbpt_pkg::FRAME_W-1:0]       table_rdata;
    logic [PAGE_COUNT-1:0]               table_valid_reg;
    logic [tlbpt_pkg::FREE_W-1:0]        free_reg;
    logic [tlbpt_pkg::FREE_W-1:0]        free_next;
    logic [tlbpt_pkg::COUNT_W-1:0]       hits_reg;
    logic [tlbpt_pkg::COUNT_W-1:0]       hits_next;
    logic [tlbpt_pkg::COUNT_W-1:0]       faults_reg;
    logic [tlbpt_pkg::COUNT_W-1:0]       faults_next;

    logic                                in_range;
    logic                                hit;
    logic                                table_hit;
    logic                                fault;
    logic                                exhausted;
    logic [tlbpt_pkg::FRAME_W-1:0]       frame;
    logic [tlbpt_pkg::ADDR_W-1:0]        phys;

    logic                                done_reg;
    logic [tlbpt_pkg::ADDR_W-1:0]        phys_reg;
    logic                                hit_reg;
    logic                                fault_reg;
    logic                                exhausted_reg;

    tlbpt_pkg::tlbpt_lookup_t            lookup;
    tlbpt_pkg::tlbpt_update_t            upd;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign rd_idx = logical_address[tlbpt_pkg::OFFSET_W +: IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_s1_reg   <= logical_address[tlbpt_pkg::ADDR_W-1 -: tlbpt_pkg::PAGE_W];
            offset_s1_reg <= logical_address[tlbpt_pkg::OFFSET_W-1:0];
        end
    end

    // A page written by a fault is installed in the TLB in the same cycle, so a
    // following transaction to that page hits the TLB and never uses a stale read.
    tlbpt_ram #(
        .WIDTH (tlbpt_pkg::FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (fault),
        .waddr (page_idx),
        .wdata (free_reg[tlbpt_pkg::FRAME_W-1:0]),
        .raddr (rd_idx),
        .rdata (table_rdata)
    );

    tlbpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_tlb (
        .clk    (clk),
        .rst_n  (rst_n),
        .page   (page_s1_reg),
        .upd    (upd),
        .lookup (lookup)
    );

    assign page_idx  = page_s1_reg[IDX_W-1:0];
    assign in_range  = valid_s1_reg && ({1'b0, page_s1_reg} < PAGE_LIMIT);
    assign hit       = in_range && lookup.hit;
    assign table_hit = in_range && !lookup.hit && table_valid_reg[page_idx];
    assign fault     = in_range && !lookup.hit && !table_valid_reg[page_idx]
                       && (free_reg < PAGE_LIMIT);
    assign exhausted = in_range && !lookup.hit && !table_valid_reg[page_idx]
                       && !(free_reg < PAGE_LIMIT);

    always_comb
    begin
        if (hit)
        begin
            frame = lookup.frame;
        end
        else if (table_hit)
        begin
            frame = table_rdata;
        end
        else
        begin
            frame = free_reg[tlbpt_pkg::FRAME_W-1:0];
        end
        phys = (hit || table_hit || fault) ? {frame, offset_s1_reg} : '0;
    end

    assign upd.touch   = hit;
    assign upd.install = fault;
    assign upd.frame   = free_reg[tlbpt_pkg::FRAME_W-1:0];

    assign free_next   = fault ? free_reg + 1'b1 : free_reg;
    assign hits_next   = (hit && (hits_reg != tlbpt_pkg::COUNT_MAX)) ? hits_reg + 1'b1
                                                                      : hits_reg;
    assign faults_next = (fault && (faults_reg != tlbpt_pkg::COUNT_MAX)) ? faults_reg + 1'b1
                                                                          : faults_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_valid_reg <= '0;
            free_reg        <= '0;
            hits_reg        <= '0;
            faults_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (fault)
            begin
                table_valid_reg[page_idx] <= 1'b1;
            end
            free_reg   <= free_next;
            hits_reg   <= hits_next;
            faults_reg <= faults_next;
            done_reg   <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        phys_reg      <= phys;
        hit_reg       <= hit;
        fault_reg     <= fault;
        exhausted_reg <= exhausted;
    end

    // The totals registers change only with a result, so they match it in the done cycle.
    assign done             = done_reg;
    assign physical_address = phys_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;
    assign frames_exhausted = exhausted_reg;
    assign hit_total        = hits_reg;
    assign fault_total      = faults_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $countones({tlb_hit, page_fault, frames_exhausted}) <= 1)
        else $error("translator: more than one outcome flag in a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        fault |=> free_reg == $past(free_reg) + 1'b1)
        else $error("translator: frame allocator did not advance on a fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && frames_exhausted) |-> physical_address == '0)
        else $error("translator: exhausted result carries an address");

endmodule
